// ===== rtl/dark_pixel_classifier_top_assert.svh =====
// Assertion helpers for the dark pixel classifier.
// Both sample on clk and are switched off while rst is high.
`ifndef DARK_PIXEL_CLASSIFIER_TOP_ASSERT_SVH
`define DARK_PIXEL_CLASSIFIER_TOP_ASSERT_SVH

// Same-cycle implication.
`define DPC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define DPC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/dpc_pkg.sv =====
package dpc_pkg;

  // Square root: radicand is S << 16, a 34-bit word, giving a 17-bit Q9.8 root
  localparam int S_W    = 17;
  localparam int ROOT_W = 17;
  localparam int RAD_W  = 2 * ROOT_W;
  localparam int REM_W  = 20;

  // Gray level: (30r + 59g + 11b) / 100 as a reciprocal multiply
  localparam int GSUM_W      = 15;
  localparam int GPROD_W     = 28;
  localparam int GRAY_SHIFT  = 19;
  localparam logic [12:0] GRAY_RECIP = 13'd5243;
  localparam logic [5:0]  W_RED      = 6'd30;
  localparam logic [5:0]  W_GREEN    = 6'd59;
  localparam logic [5:0]  W_BLUE     = 6'd11;

  // Distance full scale in integer units (Q9.8 scale added separately)
  localparam logic [8:0] DIST_DEN = 9'd411;

  // Registers after the root chain, output register included
  localparam int POST_STAGES = 8;

  // Register map (index is paddr[2])
  localparam logic REG_DARK_THRESHOLD = 1'b0;
  localparam logic [7:0] THRESH_RESET = 8'd128;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [7:0] darkness;
    logic       is_black;
  } result_t;

  // State handed from one root cell to the next
  typedef struct packed {
    logic              valid;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
    logic [RAD_W-1:0]  rad;
    logic [GSUM_W-1:0] gsum;
  } root_state_t;

endpackage

// ===== rtl/dpc_root_cell.sv =====
// One radix-2 digit of the restoring square root: takes two radicand bits,
// produces one root bit, registers the state for the next cell.
module dpc_root_cell import dpc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  root_state_t din,
  output root_state_t dout
);

  logic [REM_W-1:0] rem_sh;
  logic [REM_W-1:0] trial;
  logic             fits;

  always_comb begin
    rem_sh = {din.rem[REM_W-3:0], din.rad[RAD_W-1 -: 2]};
    trial  = REM_W'({din.root, 2'b01});
    fits   = (rem_sh >= trial);
  end

  // only the valid bit is reset; the data fields just follow it
  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else begin
      dout.valid <= din.valid;
    end
    dout.rem  <= fits ? (rem_sh - trial) : rem_sh;
    dout.root <= {din.root[ROOT_W-2:0], fits};
    dout.rad  <= {din.rad[RAD_W-3:0], 2'b00};
    dout.gsum <= din.gsum;
  end

endmodule

// ===== rtl/dpc_post.sv =====
// Ratio, fourth power, gray scaling and threshold compare: eight registers.
module dpc_post import dpc_pkg::*; #(
  parameter int RATIO_FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  root_state_t din,
  input  logic [7:0]  threshold,
  output logic        done,
  output result_t     result
);

  localparam int F  = RATIO_FRAC_BITS;
  localparam int XW = ROOT_W + F - 8;    // dist scaled to the ratio format
  localparam int K  = XW + 1;            // reciprocal shift
  localparam int MW = K - 8;             // reciprocal width
  localparam int PW = XW + MW;
  localparam int QW = F + 1;
  localparam int CW = XW + 1;
  localparam int RW = F + 1;
  localparam int SW = RW + 8;
  localparam logic [MW-1:0] RECIP = MW'((64'd1 << K) / 64'(DIST_DEN));
  localparam logic [RW-1:0] ONE   = {1'b1, {F{1'b0}}};

  logic              s1_valid, s2_valid, s3_valid, s4_valid;
  logic              s5_valid, s6_valid, s7_valid;
  logic [XW-1:0]     s1_x, s2_x, s3_x;
  logic [PW-1:0]     s1_prod;
  logic [GPROD_W-1:0] s1_gprod;
  logic [QW-1:0]     s2_q0, s3_q0;
  logic [CW-1:0]     s3_chk;
  logic [7:0]        s2_inv, s3_inv, s4_inv, s5_inv, s6_inv;
  logic [RW-1:0]     s4_ratio;
  logic [2*RW-1:0]   s5_sq1, s6_sq2;
  logic [SW-1:0]     s7_sc;

  logic [XW-1:0]     x_in;
  logic [CW-1:0]     diff;
  logic [QW-1:0]     quot;
  logic [RW-1:0]     ratio;
  logic [RW-1:0]     r2;
  logic [RW-1:0]     p4;
  logic [8:0]        score;

  always_comb begin
    x_in  = XW'(din.root) << (F - 8);
    diff  = {1'b0, s3_x} - s3_chk;
    // reciprocal estimate is at most one low
    quot  = (diff >= CW'(DIST_DEN)) ? (s3_q0 + QW'(1)) : s3_q0;
    ratio = (quot > QW'(ONE)) ? '0 : (ONE - RW'(quot));
    r2    = s5_sq1[F +: RW];
    p4    = s6_sq2[F +: RW];
    score = s7_sc[F +: 9];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
      s5_valid <= 1'b0;
      s6_valid <= 1'b0;
      s7_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      s1_valid <= din.valid;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
      s5_valid <= s4_valid;
      s6_valid <= s5_valid;
      s7_valid <= s6_valid;
      done     <= s7_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_x     <= x_in;
    s1_prod  <= PW'(x_in) * PW'(RECIP);
    s1_gprod <= GPROD_W'(din.gsum) * GPROD_W'(GRAY_RECIP);

    s2_x     <= s1_x;
    s2_q0    <= s1_prod[K +: QW];
    s2_inv   <= 8'd255 - s1_gprod[GRAY_SHIFT +: 8];

    s3_x     <= s2_x;
    s3_q0    <= s2_q0;
    s3_chk   <= CW'(s2_q0) * CW'(DIST_DEN);
    s3_inv   <= s2_inv;

    s4_ratio <= ratio;
    s4_inv   <= s3_inv;

    s5_sq1   <= (2*RW)'(s4_ratio) * (2*RW)'(s4_ratio);
    s5_inv   <= s4_inv;

    s6_sq2   <= (2*RW)'(r2) * (2*RW)'(r2);
    s6_inv   <= s5_inv;

    s7_sc    <= SW'(s6_inv) * SW'(p4);

    result.darkness <= (score > 9'd255) ? 8'd255 : score[7:0];
    result.is_black <= (((score > 9'd255) ? 8'd255 : score[7:0]) > threshold);
  end

endmodule

// ===== rtl/dark_pixel_classifier_top.sv =====
// Channel     Dir  Handshake                     Payload
// request     in   start, accepted when !busy    pixel (red, green, blue)
// result      out  done, one-cycle strobe        result (darkness, is_black)
// config      in   APB psel/penable/pwrite       dark_threshold at byte addr 0
//
// One pixel per clock, every clock; busy is never raised.
// Pipeline: input register, 17 root cells, 8 post registers.
// The root cells each resolve one bit of the Q9.8 distance.
// rst (synchronous, active high) clears valid bits and sets the threshold to 128.
// No stalls: the receiver must take done/result in the cycle they appear.
`include "dark_pixel_classifier_top_assert.svh"

module dark_pixel_classifier_top import dpc_pkg::*; #(
  parameter int RATIO_FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  // request side
  input  logic        start,
  output logic        busy,
  input  pixel_t      pixel,
  // result side
  output logic        done,
  output result_t     result,
  // config port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int LATENCY = 1 + ROOT_W + POST_STAGES;

  logic        in_valid;
  pixel_t      in_pix;
  logic [7:0]  threshold;

  // channel differences and the sum of their squares
  logic [7:0]  d_rg, d_rb, d_gb;
  logic [S_W-1:0] ssum;

  root_state_t chain [0:ROOT_W];

  // the pipeline never holds a request off
  assign busy   = 1'b0;
  assign pready = 1'b1;

  // config: one register, index in paddr[2]
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THRESH_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_DARK_THRESHOLD) begin
      threshold <= pwdata[7:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_DARK_THRESHOLD) begin
      prdata = {24'd0, threshold};
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    in_pix <= pixel;
  end

  always_comb begin
    d_rg = (in_pix.red > in_pix.green) ? (in_pix.red - in_pix.green)
                                       : (in_pix.green - in_pix.red);
    d_rb = (in_pix.red > in_pix.blue) ? (in_pix.red - in_pix.blue)
                                      : (in_pix.blue - in_pix.red);
    d_gb = (in_pix.green > in_pix.blue) ? (in_pix.green - in_pix.blue)
                                        : (in_pix.blue - in_pix.green);
    ssum = S_W'(16'(d_rg) * 16'(d_rg)) + S_W'(16'(d_rb) * 16'(d_rb))
         + S_W'(16'(d_gb) * 16'(d_gb));

    chain[0].valid = in_valid;
    chain[0].rem   = '0;
    chain[0].root  = '0;
    // radicand S << 16 puts the root in Q9.8
    chain[0].rad   = {1'b0, ssum, 16'd0};
    chain[0].gsum  = GSUM_W'(W_RED) * GSUM_W'(in_pix.red)
                   + GSUM_W'(W_GREEN) * GSUM_W'(in_pix.green)
                   + GSUM_W'(W_BLUE) * GSUM_W'(in_pix.blue);
  end

  // root chain: cell i settles distance bit ROOT_W-1-i
  for (genvar i = 0; i < ROOT_W; i++) begin : g_cell
    dpc_root_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .din  (chain[i]),
      .dout (chain[i+1])
    );
  end

  dpc_post #(
    .RATIO_FRAC_BITS (RATIO_FRAC_BITS)
  ) u_post (
    .clk       (clk),
    .rst       (rst),
    .din       (chain[ROOT_W]),
    .threshold (threshold),
    .done      (done),
    .result    (result)
  );

  // every result traces back to a request a fixed latency earlier
  `DPC_ASSERT_IMPL(a_done_has_request, done, $past(start && !busy, LATENCY), "result without request")
  // flag agrees with the score and the threshold in force
  `DPC_ASSERT_IMPL(a_flag_matches, done, result.is_black == (result.darkness > threshold), "is_black mismatch")
  // a threshold write lands on the next cycle
  `DPC_ASSERT_NEXT(a_cfg_write, psel && penable && pwrite && paddr[2] == REG_DARK_THRESHOLD, threshold == $past(pwdata[7:0]), "threshold write lost")

endmodule

// ===== tb/sv/dark_pixel_classifier_checker.sv =====
`timescale 1ns / 100ps

// Scoreboard for the dark pixel classifier: tracks the threshold register,
// predicts a score per accepted pixel and matches it against each done strobe.
module dark_pixel_classifier_checker import dpc_pkg::*; #(
  parameter int RATIO_FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  pixel_t      pixel,
  input  logic        done,
  input  result_t     result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic [31:0] prdata,
  input  logic        pready,
  output int          mismatches,
  output int          outstanding
);

  localparam logic [63:0] DIST_FULL_SCALE = 64'd411 << 8;  // 411 in Q9.8

  logic [7:0] thresh_model;
  result_t    expected_scores[$];

  function automatic logic [63:0] diff_sq(input logic [7:0] a, input logic [7:0] b);
    logic [63:0] d;
    d = (a > b) ? 64'(a - b) : 64'(b - a);
    return d * d;
  endfunction

  // floor(sqrt(v)), one result bit per pass
  function automatic logic [63:0] int_sqrt(input logic [63:0] v);
    logic [63:0] rem;
    logic [63:0] root;
    logic [63:0] probe;
    rem   = v;
    root  = '0;
    probe = 64'd1 << 62;
    while (probe > rem) probe = probe >> 2;
    while (probe != 0) begin
      if (rem >= root + probe) begin
        rem  = rem - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe = probe >> 2;
    end
    return root;
  endfunction

  function automatic result_t classify_pixel(input pixel_t p, input logic [7:0] thresh);
    logic [63:0] one;
    logic [63:0] chroma_sq;
    logic [63:0] chroma_dist;
    logic [63:0] quot;
    logic [63:0] ratio;
    logic [63:0] gray;
    logic [63:0] score;
    result_t     r;
    one         = 64'd1 << RATIO_FRAC_BITS;
    chroma_sq   = diff_sq(p.red, p.green) + diff_sq(p.red, p.blue)
                + diff_sq(p.green, p.blue);
    chroma_dist = int_sqrt(chroma_sq << 16);
    quot        = (chroma_dist << RATIO_FRAC_BITS) / DIST_FULL_SCALE;
    ratio       = (quot > one) ? 64'd0 : one - quot;
    ratio       = (ratio * ratio) >> RATIO_FRAC_BITS;
    ratio       = (ratio * ratio) >> RATIO_FRAC_BITS;
    gray        = (64'd30 * p.red + 64'd59 * p.green + 64'd11 * p.blue) / 64'd100;
    score       = ((64'd255 - gray) * ratio) >> RATIO_FRAC_BITS;
    if (score > 64'd255) score = 64'd255;
    r.darkness = score[7:0];
    r.is_black = (score[7:0] > thresh);
    return r;
  endfunction

  always @(posedge clk) begin : monitor
    result_t want;
    if (rst) begin
      thresh_model = THRESH_RESET;
      expected_scores.delete();
      mismatches   = 0;
    end else begin
      // results first, so a stray strobe never pairs with this cycle's pixel
      if (done) begin
        if (expected_scores.size() == 0) begin
          $error("result: unexpected done, darkness %0d is_black %0d",
                 result.darkness, result.is_black);
          mismatches++;
        end else begin
          want = expected_scores.pop_front();
          if (result.darkness !== want.darkness) begin
            $error("darkness: expected %0d, got %0d", want.darkness, result.darkness);
            mismatches++;
          end
          if (result.is_black !== want.is_black) begin
            $error("is_black: expected %0d, got %0d", want.is_black, result.is_black);
            mismatches++;
          end
        end
      end
      if (start && !busy)
        expected_scores.insert(expected_scores.size(), classify_pixel(pixel, thresh_model));
      if (psel && penable && pready && paddr[2] == REG_DARK_THRESHOLD) begin
        if (pwrite) begin
          thresh_model = pwdata[7:0];
        end else if (prdata !== {24'h0, thresh_model}) begin
          $error("dark_threshold: expected %0d, got %0d", thresh_model, prdata);
          mismatches++;
        end
      end
    end
    outstanding = expected_scores.size();
  end

endmodule

// ===== tb/sv/tb_dark_pixel_classifier_top.sv =====
`timescale 1ns / 100ps

// Stimulus and verdict for the dark pixel classifier. All checking lives in
// the scoreboard instance beside the DUT; this module only drives the request
// and config ports and watches for a stalled run.
module tb_dark_pixel_classifier_top;
  import dpc_pkg::*;

  localparam int RATIO_FRAC_BITS = 16;

  // byte addresses on the config port
  localparam logic [2:0] ADDR_DARK_THRESHOLD = 3'd0;
  localparam logic [2:0] ADDR_UNMAPPED       = 3'd4;   // out of range, write dropped

  localparam int PIPE_LATENCY   = 26;
  localparam int DRAIN_CYCLES   = PIPE_LATENCY + 16;
  localparam int WATCHDOG_LIMIT = 2000;  // idle cycles
  localparam int PHASE_ITEMS    = 185;   // six random phases, ~1100 pixels

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  pixel_t      pixel = '0;
  logic        done;
  result_t     result;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int mismatches;
  int outstanding;
  int idle_cycles;

  // 12 ns period
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  dark_pixel_classifier_top #(.RATIO_FRAC_BITS(RATIO_FRAC_BITS)) u_top (
    .clk, .rst, .start, .busy, .pixel, .done, .result,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  dark_pixel_classifier_checker #(.RATIO_FRAC_BITS(RATIO_FRAC_BITS)) u_checker (
    .clk, .rst, .start, .busy, .pixel, .done, .result,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .mismatches, .outstanding
  );

  // Watchdog: any request, result or config access resets the count.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (psel && penable && pready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Drive one request and hold it until the DUT takes it. Returns on the
  // falling edge after acceptance with start still high, so back-to-back
  // requests never drop start within a time step.
  task automatic push_pixel(input pixel_t p);
    start <= 1'b1;
    pixel <= p;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  // Two-phase APB transfer; the access completes on the first edge with pready.
  // The bus then idles before the next transfer.
  task automatic apb_access(input logic wr, input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  // Stop sending and let the pipe empty. Every pixel yields a result, so an
  // empty scoreboard means nothing is left in flight.
  task automatic wait_drained();
    start <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
  endtask

  // Threshold change: junk in the upper bits checks the 8-bit mask, the
  // read-back checks the register, and an unmapped write must not land.
  task automatic set_threshold(input logic [7:0] thresh);
    wait_drained();
    apb_access(1'b1, ADDR_DARK_THRESHOLD, ($urandom() & 32'hFFFF_FF00) | thresh);
    apb_access(1'b1, ADDR_UNMAPPED, $urandom());
    apb_access(1'b0, ADDR_DARK_THRESHOLD, '0);
  endtask

  function automatic logic [7:0] clamp_byte(input int v);
    return (v < 0) ? 8'd0 : (v > 255) ? 8'd255 : 8'(v);
  endfunction

  // Pixel mix: plain noise gives low scores, so half the pixels are near-gray
  // (high ratio) to push darkness across the whole range and past any threshold.
  function automatic pixel_t random_pixel();
    pixel_t p;
    int     base;
    int     spread;
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        p = pixel_t'($urandom());
      end
      3, 4: begin                       // exact gray, zero chroma distance
        p.red   = 8'($urandom());
        p.green = p.red;
        p.blue  = p.red;
      end
      5, 6: begin                       // near-gray anywhere in the range
        base    = $urandom_range(0, 255);
        spread  = $urandom_range(1, 24);
        p.red   = clamp_byte(base + $urandom_range(0, 2 * spread) - spread);
        p.green = clamp_byte(base + $urandom_range(0, 2 * spread) - spread);
        p.blue  = clamp_byte(base + $urandom_range(0, 2 * spread) - spread);
      end
      7: begin                          // saturated corners
        p.red   = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        p.green = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        p.blue  = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      end
      8: begin                          // dark, almost colorless
        base    = $urandom_range(0, 40);
        p.red   = clamp_byte(base + $urandom_range(0, 6) - 3);
        p.green = clamp_byte(base + $urandom_range(0, 6) - 3);
        p.blue  = clamp_byte(base + $urandom_range(0, 6) - 3);
      end
      default: begin                    // one free channel against extremes
        p.red   = 8'($urandom());
        p.green = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        p.blue  = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      end
    endcase
    return p;
  endfunction

  // Bursts of random length with random gaps; an occasional long burst
  // keeps full-rate stretches in the mix.
  task automatic send_pixels(input int count);
    int sent;
    int burst;
    int gap;
    sent = 0;
    while (sent < count) begin
      burst = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 150) : $urandom_range(1, 12);
      for (int k = 0; k < burst && sent < count; k++) begin
        push_pixel(random_pixel());
        sent++;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
      if (gap != 0) begin
        start <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  endtask

  initial begin : stimulus
    pixel_t      directed[$];
    logic [7:0]  thresh_plan[$];

    // extremes, primaries, gray levels and near-gray edge cases
    directed = '{
      '{8'h00, 8'h00, 8'h00}, '{8'hFF, 8'hFF, 8'hFF}, '{8'hFF, 8'h00, 8'h00},
      '{8'h00, 8'hFF, 8'h00}, '{8'h00, 8'h00, 8'hFF}, '{8'hFF, 8'hFF, 8'h00},
      '{8'hFF, 8'h00, 8'hFF}, '{8'h00, 8'hFF, 8'hFF}, '{8'h80, 8'h80, 8'h80},
      '{8'h01, 8'h01, 8'h01}, '{8'hFE, 8'hFE, 8'hFE}, '{8'h0A, 8'h0C, 8'h0B},
      '{8'h00, 8'h00, 8'h01}, '{8'hFF, 8'h00, 8'h80}, '{8'hAA, 8'h55, 8'hAA},
      '{8'h55, 8'hAA, 8'h55}, '{8'h10, 8'h00, 8'h10}, '{8'h7F, 8'h80, 8'h7F}
    };
    // reset value is exercised first; then both ends and their neighbors
    thresh_plan = '{8'd0, 8'd255, 8'd1, 8'd254, 8'($urandom()), 8'($urandom())};

    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset threshold: read it back, then the directed pixels
    apb_access(1'b0, ADDR_DARK_THRESHOLD, '0);
    foreach (directed[i]) push_pixel(directed[i]);
    send_pixels(40);

    foreach (thresh_plan[i]) begin
      set_threshold(thresh_plan[i]);
      if (i == 2) begin
        // mid-phase hold-off until the scoreboard is empty
        send_pixels(PHASE_ITEMS / 2);
        wait_drained();
        send_pixels(PHASE_ITEMS - PHASE_ITEMS / 2);
      end else begin
        send_pixels(PHASE_ITEMS);
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (mismatches == 0 && outstanding == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
